>>> src/sspe_pkg.sv
// Package for the spectrum smoothing and peak extraction unit.
// Holds the item and result structs, the sizing constants and the peak test.
// No dependencies.
package sspe_pkg;

    localparam int BINS  = 256;
    localparam int BIN_W = $clog2(BINS);
    localparam int TOT_W = 32 + BIN_W;
    localparam int DEN_W = TOT_W + BIN_W;
    localparam int PRD_W = 32 + TOT_W;

    localparam logic [BIN_W-1:0] LAST_BIN   = BIN_W'(BINS - 1);
    localparam logic [31:0]      THRESH     = 32'((64'(BINS) * 64'd65536) / 64'd100);
    localparam logic [16:0]      BETA_MAX   = 17'd58982;
    localparam logic [15:0]      BETA_RESET = 16'd52429;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_PROCESS = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  bin_index;
        logic [31:0] magnitude;
    } t_item;

    typedef struct packed {
        logic [31:0] peak_value;
        logic [7:0]  peak_count;
        logic        saturated;
    } t_result;

    // A bin is a peak when it is not bin 0, lies above the threshold and
    // lies strictly above both neighbours.
    function automatic logic is_peak(logic [BIN_W-1:0] idx, logic [31:0] prev,
                                     logic [31:0] cur, logic [31:0] nxt);
        return (idx != '0) && (cur > THRESH) && (cur > prev) && (cur > nxt);
    endfunction

endpackage

>>> src/spectrum_smooth_peak_extract_unit.sv
// Top level of the spectrum smoothing and peak extraction unit.
// Depends on sspe_pkg for the item and result types and sizing constants.
//
// Usage: an item is taken at a rising edge where start is high and busy is
// low. The item's action selects a bin write, a frame process or a bin read.
// Every item produces exactly one result, shown on o_result for one cycle
// with o_result_stb high; the receiver cannot hold it off.
// A write folds the magnitude into the smoothed spectrum through a memory
// read, two multipliers and a write back. A process walks the smoothed
// memory twice, one bin at a time through its single read port; on the
// second pass a bit-serial divider produces one quotient bit a cycle.
// busy stays high until the result is shown; the next item may start in the
// cycle of the strobe. Reset returns the smoothing weight to 0.8 and makes
// every bin of both spectra read as zero; valid bits for the smoothed
// spectrum and one flag for the output spectrum stand in for a clearing pass,
// so the block accepts items from the first cycle after reset.
// The user must write the smoothing weight through i_cfg_we / i_cfg_data
// only while idle; the block itself does not enforce this.
module spectrum_smooth_peak_extract_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sspe_pkg::t_item      i_item,
    output sspe_pkg::t_result    o_result,
    output logic                 o_result_stb,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data
);

    localparam int BW = sspe_pkg::BIN_W;
    localparam int TW = sspe_pkg::TOT_W;
    localparam int DW = sspe_pkg::DEN_W;
    localparam int PW = sspe_pkg::PRD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_WR1, S_WR2, S_RD, S_NOP, S_PRIME, S_NEXT, S_EVAL,
        S_ACT, S_DEN, S_MUL, S_SUM, S_CHK, S_DIV, S_ADV
    } t_state;

    t_state r_st;

    // Smoothed spectrum memory with per-bin valid bits.
    logic [31:0]   r_smem [sspe_pkg::BINS];
    logic          r_sval [sspe_pkg::BINS];
    logic [31:0]   r_sdat;
    logic          r_sv_q;
    logic [BW-1:0] s_ra;
    logic          s_we;
    logic [31:0]   s_wd;
    logic [31:0]   sdat_m;

    // Output spectrum memory; every entry is rewritten by each process.
    logic [31:0]   r_pmem [sspe_pkg::BINS];
    logic [31:0]   r_pdat;
    logic          r_peak_init;
    logic          r_pw_en;
    logic [31:0]   r_pw_d;

    logic [15:0]   r_beta;
    logic [16:0]   beta_eff;

    // Item and working registers.
    logic [BW-1:0] r_idx;
    logic          r_ok;
    logic [31:0]   r_mag;
    logic [47:0]   r_pa;
    logic [48:0]   r_pb;
    logic [49:0]   acc;

    logic          r_pass;
    logic [BW-1:0] r_i;
    logic [31:0]   r_w0, r_w1, r_w2;
    logic          r_pk;
    logic [TW-1:0] r_tot, r_kept;
    logic [7:0]    r_cnt, r_found;
    logic          r_satw, r_sat;
    logic [DW-1:0] r_den;
    logic [63:0]   r_plo;
    logic [TW-1:0] r_phi;
    logic [PW-1:0] r_prod;
    logic [DW-1:0] r_rem;
    logic [31:0]   r_lo, r_q;
    logic [4:0]    r_k;
    logic [DW:0]   div_t;
    logic          div_ge;
    logic [31:0]   nxt_val;

    assign busy     = (r_st != S_IDLE);
    assign beta_eff = ({1'b0, r_beta} > sspe_pkg::BETA_MAX) ? sspe_pkg::BETA_MAX
                                                           : {1'b0, r_beta};
    assign sdat_m   = r_sv_q ? r_sdat : 32'd0;
    assign nxt_val  = (r_i == sspe_pkg::LAST_BIN) ? 32'd0 : sdat_m;
    assign acc      = 50'(r_pa) + 50'(r_pb) + 50'd32768;
    assign s_we     = (r_st == S_WR2) && r_ok;
    assign s_wd     = acc[47:16];
    assign div_t    = {r_rem, r_lo[31]};
    assign div_ge   = div_t >= {1'b0, r_den};

    // Read address of the smoothed memory follows the state.
    always_comb begin
        unique case (r_st)
            S_IDLE:  s_ra = (i_item.action == sspe_pkg::ACT_PROCESS) ? '0
                                                                     : BW'(i_item.bin_index);
            S_NEXT:  s_ra = r_i + BW'(1);
            default: s_ra = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[r_idx] <= s_wd;
        end
        r_sdat <= r_smem[s_ra];
        r_sv_q <= r_sval[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sspe_pkg::BINS; k++) begin
                r_sval[k] <= 1'b0;
            end
        end else if (s_we) begin
            r_sval[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pw_en) begin
            r_pmem[r_i] <= r_pw_d;
        end
        r_pdat <= r_pmem[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= sspe_pkg::BETA_RESET;
        end else if (i_cfg_we) begin
            r_beta <= i_cfg_data;
        end
    end

    // Sequencer: holds state, the working registers and the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= S_IDLE;
            r_peak_init  <= 1'b0;
            r_pw_en      <= 1'b0;
            r_found      <= '0;
            r_sat        <= 1'b0;
            o_result_stb <= 1'b0;
            o_result     <= '0;
        end else begin
            o_result_stb <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (start) begin
                        r_idx <= BW'(i_item.bin_index);
                        r_ok  <= 32'(i_item.bin_index) < sspe_pkg::BINS;
                        r_mag <= i_item.magnitude;
                        unique case (i_item.action)
                            sspe_pkg::ACT_WRITE: r_st <= S_WR1;
                            sspe_pkg::ACT_READ:  r_st <= S_RD;
                            sspe_pkg::ACT_PROCESS: begin
                                r_pass <= 1'b0;
                                r_i    <= '0;
                                r_tot  <= '0;
                                r_kept <= '0;
                                r_cnt  <= '0;
                                r_satw <= 1'b0;
                                r_st   <= S_PRIME;
                            end
                            default: r_st <= S_NOP;
                        endcase
                    end
                end
                S_WR1: begin
                    r_pa <= 48'(sdat_m) * 48'(beta_eff);
                    r_pb <= 49'(r_mag) * 49'(17'h10000 - beta_eff);
                    r_st <= S_WR2;
                end
                S_WR2: begin
                    o_result     <= '{peak_value: 32'd0, peak_count: r_found,
                                      saturated: r_sat};
                    o_result_stb <= 1'b1;
                    r_st         <= S_IDLE;
                end
                S_RD: begin
                    o_result     <= '{peak_value: (r_ok && r_peak_init) ? r_pdat : 32'd0,
                                      peak_count: r_found, saturated: r_sat};
                    o_result_stb <= 1'b1;
                    r_st         <= S_IDLE;
                end
                S_NOP: begin
                    o_result     <= '{peak_value: 32'd0, peak_count: r_found,
                                      saturated: r_sat};
                    o_result_stb <= 1'b1;
                    r_st         <= S_IDLE;
                end
                S_PRIME: begin
                    r_w0 <= 32'd0;
                    r_w1 <= sdat_m;
                    r_st <= S_NEXT;
                end
                S_NEXT: begin
                    r_st <= S_EVAL;
                end
                S_EVAL: begin
                    r_w2 <= nxt_val;
                    r_pk <= sspe_pkg::is_peak(r_i, r_w0, r_w1, nxt_val);
                    r_st <= S_ACT;
                end
                S_ACT: begin
                    if (!r_pass) begin
                        r_tot <= r_tot + TW'(r_w1);
                        if (r_pk) begin
                            r_kept <= r_kept + TW'(r_w1);
                            if (r_cnt != 8'hFF) begin
                                r_cnt <= r_cnt + 8'd1;
                            end
                        end
                        r_st <= S_ADV;
                    end else if (r_w1 != 32'd0 && r_den != '0
                                 && (r_cnt == 8'd0 || r_pk)) begin
                        r_st <= S_MUL;
                    end else begin
                        r_pw_en <= 1'b1;
                        r_pw_d  <= 32'd0;
                        r_st    <= S_ADV;
                    end
                end
                S_DEN: begin
                    // With no peaks the kept energy is the total energy.
                    r_den  <= DW'((r_cnt == 8'd0) ? r_tot : r_kept)
                              * DW'(sspe_pkg::BINS);
                    r_pass <= 1'b1;
                    r_i    <= '0;
                    r_st   <= S_PRIME;
                end
                S_MUL: begin
                    r_plo <= 64'(r_w1) * 64'(r_tot[31:0]);
                    r_phi <= TW'(r_w1) * TW'(r_tot[TW-1:32]);
                    r_st  <= S_SUM;
                end
                S_SUM: begin
                    r_prod <= PW'(r_plo) + (PW'(r_phi) << 32);
                    r_st   <= S_CHK;
                end
                S_CHK: begin
                    // A quotient of 2^32 or more saturates.
                    if (DW'(r_prod[PW-1:32]) >= r_den) begin
                        r_pw_en <= 1'b1;
                        r_pw_d  <= 32'hFFFF_FFFF;
                        r_satw  <= 1'b1;
                        r_st    <= S_ADV;
                    end else begin
                        r_rem <= DW'(r_prod[PW-1:32]);
                        r_lo  <= r_prod[31:0];
                        r_q   <= '0;
                        r_k   <= '0;
                        r_st  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? DW'(div_t - {1'b0, r_den}) : DW'(div_t);
                    r_q   <= {r_q[30:0], div_ge};
                    r_lo  <= {r_lo[30:0], 1'b0};
                    r_k   <= r_k + 5'd1;
                    if (r_k == 5'd31) begin
                        r_pw_en <= 1'b1;
                        r_pw_d  <= {r_q[30:0], div_ge};
                        r_st    <= S_ADV;
                    end
                end
                S_ADV: begin
                    r_pw_en <= 1'b0;
                    if (r_i == sspe_pkg::LAST_BIN) begin
                        if (!r_pass) begin
                            r_st <= S_DEN;
                        end else begin
                            r_found      <= r_cnt;
                            r_sat        <= r_satw;
                            r_peak_init  <= 1'b1;
                            o_result     <= '{peak_value: 32'd0, peak_count: r_cnt,
                                              saturated: r_satw};
                            o_result_stb <= 1'b1;
                            r_st         <= S_IDLE;
                        end
                    end else begin
                        r_w0 <= r_w1;
                        r_w1 <= r_w2;
                        r_i  <= r_i + BW'(1);
                        r_st <= S_NEXT;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_stb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_stb |-> !busy)
        else $error("result shown while busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder out of range");
    a_count_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found != 8'd0) |-> r_peak_init)
        else $error("peak count without a processed frame");
`endif

endmodule
